/* design/lfr_pkg.sv */
// Shared types, codes and constants for the line fit block.
package lfr_pkg;

    localparam int MAX_POINTS = 256;
    localparam int DIV_W      = 84;

    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_FIT = 2'd1;
    localparam logic [1:0] KIND_RES = 2'd2;

    localparam logic       RKIND_FIT = 1'b0;
    localparam logic       RKIND_RES = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DEGEN = 2'd1;
    localparam logic [1:0] ST_DROP  = 2'd2;
    localparam logic [1:0] ST_NOFIT = 2'd3;

    typedef struct packed {
        logic [1:0]          kind;
        logic signed [23:0]  x_coord;
        logic signed [23:0]  y_coord;
    } in_item_t;

    typedef struct packed {
        logic                result_kind;
        logic signed [31:0]  slope;
        logic signed [23:0]  intercept;
        logic signed [23:0]  residual;
        logic [8:0]          points_used;
        logic [1:0]          status;
    } out_item_t;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_ACC1,
        OP_ACC2,
        OP_FIT1,
        OP_FIT2,
        OP_FIT3,
        OP_DIV_SLOPE,
        OP_SLOPE,
        OP_OFF1,
        OP_OFF2,
        OP_DIV_OFF,
        OP_EMIT_FIT,
        OP_EMIT_DEGEN,
        OP_RES1,
        OP_RES2,
        OP_RES3,
        OP_DIV_RES,
        OP_EMIT_RES,
        OP_EMIT_NOLINE
    } op_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       line_valid;
        logic       degen;
        logic       div_done;
        logic       sqrt_done;
    } stat_t;

endpackage

/* design/lfr_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module lfr_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lfr_pkg::DIV_W-1:0]     dividend,
    input  logic [lfr_pkg::DIV_W-1:0]     divisor,
    output logic                          done,
    output logic [lfr_pkg::DIV_W-1:0]     quotient
);

    localparam int CW = $clog2(lfr_pkg::DIV_W + 1);

    logic [lfr_pkg::DIV_W-1:0] rem_reg, rem_next;
    logic [lfr_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [lfr_pkg::DIV_W-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic                      run_reg, run_next;
    logic                      done_reg, done_next;
    logic [lfr_pkg::DIV_W:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[lfr_pkg::DIV_W-1]};
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = CW'(lfr_pkg::DIV_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = lfr_pkg::DIV_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[lfr_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[lfr_pkg::DIV_W-1:0];
                quo_next = {quo_reg[lfr_pkg::DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !run_reg)
        else $error("divider done while running");

endmodule

/* design/lfr_sqrt.sv */
// Bitwise integer square root of a 64-bit value, two radicand bits per cycle.
module lfr_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] v_reg, v_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [63:0] trial;

    always_comb
    begin
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = res_reg + bit_reg;
        if (start)
        begin
            v_next   = radicand;
            res_next = '0;
            bit_next = 64'h4000_0000_0000_0000;
            cnt_next = 6'd32;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

/* design/lfr_dp.sv */
// Datapath: sums, products, kept line, divider and root units, result register.
module lfr_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  lfr_pkg::op_t        op,
    input  lfr_pkg::in_item_t   in_item,
    output lfr_pkg::stat_t      stat,
    output lfr_pkg::out_item_t  result,
    output logic                result_strobe
);

    function automatic logic [31:0] sat32(input logic [lfr_pkg::DIV_W-1:0] q, input logic neg);
        logic [31:0] r;
        if (q[lfr_pkg::DIV_W-1:31] != '0)
            r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            r = neg ? (32'd0 - q[31:0]) : q[31:0];
        return r;
    endfunction

    function automatic logic [23:0] sat24(input logic [lfr_pkg::DIV_W-1:0] q, input logic neg);
        logic [23:0] r;
        if (q[lfr_pkg::DIV_W-1:23] != '0)
            r = neg ? 24'h80_0000 : 24'h7F_FFFF;
        else
            r = neg ? (24'd0 - q[23:0]) : q[23:0];
        return r;
    endfunction

    logic [1:0]          kind_reg, kind_next;
    logic signed [23:0]  x_reg, x_next, y_reg, y_next;
    logic [8:0]          cnt_reg, cnt_next;
    logic signed [31:0]  sx_reg, sx_next, sy_reg, sy_next;
    logic signed [55:0]  sxx_reg, sxx_next, sxy_reg, sxy_next;
    logic                drop_reg, drop_next, add_reg, add_next;
    logic signed [31:0]  slope_reg, slope_next;
    logic signed [23:0]  off_reg, off_next;
    logic                valid_reg, valid_next;
    logic signed [66:0]  pa_reg, pa_next, pb_reg, pb_next;
    logic signed [66:0]  den_reg, den_next, num_reg, num_next;
    logic                neg_reg, neg_next;
    lfr_pkg::out_item_t  res_reg, res_next;
    logic                strobe_reg, strobe_next;

    logic signed [31:0]  mul_a, mul_b;
    logic signed [63:0]  big_prod;
    logic signed [55:0]  small_sel;
    logic signed [65:0]  small_prod;
    logic signed [47:0]  sq_prod;
    logic [66:0]         mag;
    logic                div_start, div_done, sqrt_done;
    logic [lfr_pkg::DIV_W-1:0] div_dividend, div_divisor, div_q;
    logic [31:0]         root;

    assign big_prod   = mul_a * mul_b;
    assign small_prod = $signed({1'b0, cnt_reg}) * small_sel;
    assign sq_prod    = x_reg * x_reg;
    assign mag        = num_reg[66] ? (67'd0 - num_reg) : num_reg;

    always_comb
    begin
        mul_a        = {{8{x_reg[23]}}, x_reg};
        mul_b        = {{8{y_reg[23]}}, y_reg};
        small_sel    = sxx_reg;
        div_start    = 1'b0;
        div_dividend = {16'd0, mag, 1'b0} + {52'd0, root};
        div_divisor  = {51'd0, root, 1'b0};
        unique case (op)
            lfr_pkg::OP_FIT1:
            begin
                mul_a = sx_reg;
                mul_b = sx_reg;
            end
            lfr_pkg::OP_FIT2:
            begin
                mul_a     = sx_reg;
                mul_b     = sy_reg;
                small_sel = sxy_reg;
            end
            lfr_pkg::OP_OFF1:
            begin
                mul_a = slope_reg;
                mul_b = sx_reg;
            end
            lfr_pkg::OP_RES1:
            begin
                mul_a = slope_reg;
                mul_b = slope_reg;
            end
            lfr_pkg::OP_RES2:
            begin
                mul_a = slope_reg;
                mul_b = {{8{x_reg[23]}}, x_reg};
            end
            lfr_pkg::OP_DIV_SLOPE:
            begin
                div_start    = 1'b1;
                div_dividend = {mag, 17'd0} + {17'd0, den_reg};
                div_divisor  = {16'd0, den_reg, 1'b0};
            end
            lfr_pkg::OP_DIV_OFF:
            begin
                div_start    = 1'b1;
                div_dividend = {16'd0, mag, 1'b0} + {59'd0, cnt_reg, 16'd0};
                div_divisor  = {58'd0, cnt_reg, 17'd0};
            end
            lfr_pkg::OP_DIV_RES:
            begin
                div_start = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        kind_next   = kind_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        cnt_next    = cnt_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        sxx_next    = sxx_reg;
        sxy_next    = sxy_reg;
        drop_next   = drop_reg;
        add_next    = add_reg;
        slope_next  = slope_reg;
        off_next    = off_reg;
        valid_next  = valid_reg;
        pa_next     = pa_reg;
        pb_next     = pb_reg;
        den_next    = den_reg;
        num_next    = num_reg;
        neg_next    = neg_reg;
        res_next    = res_reg;
        strobe_next = 1'b0;
        unique case (op) inside
            lfr_pkg::OP_LOAD:
            begin
                kind_next = in_item.kind;
                x_next    = in_item.x_coord;
                y_next    = in_item.y_coord;
            end
            lfr_pkg::OP_ACC1:
            begin
                if (cnt_reg < 9'(lfr_pkg::MAX_POINTS))
                begin
                    cnt_next = cnt_reg + 9'd1;
                    sx_next  = sx_reg + {{8{x_reg[23]}}, x_reg};
                    sy_next  = sy_reg + {{8{y_reg[23]}}, y_reg};
                    add_next = 1'b1;
                end
                else
                begin
                    drop_next = 1'b1;
                    add_next  = 1'b0;
                end
                pa_next = {{19{sq_prod[47]}}, sq_prod};
                pb_next = {{3{big_prod[63]}}, big_prod};
            end
            lfr_pkg::OP_ACC2:
            begin
                if (add_reg)
                begin
                    sxx_next = sxx_reg + pa_reg[55:0];
                    sxy_next = sxy_reg + pb_reg[55:0];
                end
            end
            lfr_pkg::OP_FIT1:
            begin
                pa_next = {small_prod[65], small_prod};
                pb_next = {{3{big_prod[63]}}, big_prod};
            end
            lfr_pkg::OP_FIT2:
            begin
                den_next = pa_reg - pb_reg;
                pa_next  = {small_prod[65], small_prod};
                pb_next  = {{3{big_prod[63]}}, big_prod};
            end
            lfr_pkg::OP_FIT3:
            begin
                num_next = pa_reg - pb_reg;
            end
            lfr_pkg::OP_DIV_SLOPE, lfr_pkg::OP_DIV_OFF, lfr_pkg::OP_DIV_RES:
            begin
                neg_next = num_reg[66];
            end
            lfr_pkg::OP_SLOPE:
            begin
                slope_next = sat32(div_q, neg_reg);
            end
            lfr_pkg::OP_OFF1:
            begin
                pa_next = {{19{sy_reg[31]}}, sy_reg, 16'd0};
                pb_next = {{3{big_prod[63]}}, big_prod};
            end
            lfr_pkg::OP_OFF2:
            begin
                num_next = pa_reg - pb_reg;
            end
            lfr_pkg::OP_EMIT_FIT:
            begin
                off_next             = sat24(div_q, neg_reg);
                valid_next           = 1'b1;
                res_next.result_kind = lfr_pkg::RKIND_FIT;
                res_next.slope       = slope_reg;
                res_next.intercept   = sat24(div_q, neg_reg);
                res_next.residual    = '0;
                res_next.points_used = cnt_reg;
                res_next.status      = drop_reg ? lfr_pkg::ST_DROP : lfr_pkg::ST_OK;
                strobe_next          = 1'b1;
                cnt_next  = '0;
                sx_next   = '0;
                sy_next   = '0;
                sxx_next  = '0;
                sxy_next  = '0;
                drop_next = 1'b0;
            end
            lfr_pkg::OP_EMIT_DEGEN:
            begin
                valid_next           = 1'b0;
                res_next.result_kind = lfr_pkg::RKIND_FIT;
                res_next.slope       = '0;
                res_next.intercept   = '0;
                res_next.residual    = '0;
                res_next.points_used = cnt_reg;
                res_next.status      = lfr_pkg::ST_DEGEN;
                strobe_next          = 1'b1;
                cnt_next  = '0;
                sx_next   = '0;
                sy_next   = '0;
                sxx_next  = '0;
                sxy_next  = '0;
                drop_next = 1'b0;
            end
            lfr_pkg::OP_RES1:
            begin
                pb_next = {{3{big_prod[63]}}, big_prod};
            end
            lfr_pkg::OP_RES2:
            begin
                pa_next = {{3{big_prod[63]}}, big_prod};
            end
            lfr_pkg::OP_RES3:
            begin
                num_next = {{27{y_reg[23]}}, y_reg, 16'd0} - pa_reg
                         - {{27{off_reg[23]}}, off_reg, 16'd0};
            end
            lfr_pkg::OP_EMIT_RES:
            begin
                res_next.result_kind = lfr_pkg::RKIND_RES;
                res_next.slope       = slope_reg;
                res_next.intercept   = off_reg;
                res_next.residual    = sat24(div_q, neg_reg);
                res_next.points_used = '0;
                res_next.status      = lfr_pkg::ST_OK;
                strobe_next          = 1'b1;
            end
            lfr_pkg::OP_EMIT_NOLINE:
            begin
                res_next.result_kind = lfr_pkg::RKIND_RES;
                res_next.slope       = '0;
                res_next.intercept   = '0;
                res_next.residual    = '0;
                res_next.points_used = '0;
                res_next.status      = lfr_pkg::ST_NOFIT;
                strobe_next          = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= '0;
            cnt_reg    <= '0;
            sx_reg     <= '0;
            sy_reg     <= '0;
            sxx_reg    <= '0;
            sxy_reg    <= '0;
            drop_reg   <= 1'b0;
            add_reg    <= 1'b0;
            slope_reg  <= '0;
            off_reg    <= '0;
            valid_reg  <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            kind_reg   <= kind_next;
            cnt_reg    <= cnt_next;
            sx_reg     <= sx_next;
            sy_reg     <= sy_next;
            sxx_reg    <= sxx_next;
            sxy_reg    <= sxy_next;
            drop_reg   <= drop_next;
            add_reg    <= add_next;
            slope_reg  <= slope_next;
            off_reg    <= off_next;
            valid_reg  <= valid_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        pa_reg  <= pa_next;
        pb_reg  <= pb_next;
        den_reg <= den_next;
        num_reg <= num_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    lfr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    lfr_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (op == lfr_pkg::OP_RES2),
        .radicand (64'h1_0000_0000 + pb_reg[63:0]),
        .done     (sqrt_done),
        .root     (root)
    );

    always_comb
    begin
        stat.kind       = kind_reg;
        stat.line_valid = valid_reg;
        stat.degen      = (cnt_reg < 9'd2) || den_reg[66] || (den_reg == '0);
        stat.div_done   = div_done;
        stat.sqrt_done  = sqrt_done;
    end

    assign result        = res_reg;
    assign result_strobe = strobe_reg;

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |=> !strobe_reg)
        else $error("result strobe held longer than one cycle");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 9'(lfr_pkg::MAX_POINTS))
        else $error("point count beyond capacity");

endmodule

/* design/lfr_ctrl.sv */
// Controller: sequences load, accumulate, fit and residual steps.
module lfr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  lfr_pkg::stat_t  stat,
    output lfr_pkg::op_t    op,
    output logic            busy
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_ACC1, S_ACC2,
        S_FIT1, S_FIT2, S_FIT_CHK, S_FIT3, S_FIT4, S_SL_WAIT, S_SLOPE,
        S_OFF1, S_OFF2, S_OFF3, S_OFF_WAIT, S_FIT_OUT, S_FIT_DG,
        S_RES1, S_RES2, S_RES3, S_RES_SQW, S_RES4, S_RES_DW, S_RES_OUT, S_RES_NL
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next = state_reg;
        op         = lfr_pkg::OP_IDLE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op         = lfr_pkg::OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.kind)
                    lfr_pkg::KIND_ADD: state_next = S_ACC1;
                    lfr_pkg::KIND_FIT: state_next = S_FIT1;
                    lfr_pkg::KIND_RES: state_next = stat.line_valid ? S_RES1 : S_RES_NL;
                    default:           state_next = S_IDLE;
                endcase
            end
            S_ACC1:
            begin
                op         = lfr_pkg::OP_ACC1;
                state_next = S_ACC2;
            end
            S_ACC2:
            begin
                op         = lfr_pkg::OP_ACC2;
                state_next = S_IDLE;
            end
            S_FIT1:
            begin
                op         = lfr_pkg::OP_FIT1;
                state_next = S_FIT2;
            end
            S_FIT2:
            begin
                op         = lfr_pkg::OP_FIT2;
                state_next = S_FIT_CHK;
            end
            S_FIT_CHK:
            begin
                state_next = stat.degen ? S_FIT_DG : S_FIT3;
            end
            S_FIT3:
            begin
                op         = lfr_pkg::OP_FIT3;
                state_next = S_FIT4;
            end
            S_FIT4:
            begin
                op         = lfr_pkg::OP_DIV_SLOPE;
                state_next = S_SL_WAIT;
            end
            S_SL_WAIT:
            begin
                if (stat.div_done)
                    state_next = S_SLOPE;
            end
            S_SLOPE:
            begin
                op         = lfr_pkg::OP_SLOPE;
                state_next = S_OFF1;
            end
            S_OFF1:
            begin
                op         = lfr_pkg::OP_OFF1;
                state_next = S_OFF2;
            end
            S_OFF2:
            begin
                op         = lfr_pkg::OP_OFF2;
                state_next = S_OFF3;
            end
            S_OFF3:
            begin
                op         = lfr_pkg::OP_DIV_OFF;
                state_next = S_OFF_WAIT;
            end
            S_OFF_WAIT:
            begin
                if (stat.div_done)
                    state_next = S_FIT_OUT;
            end
            S_FIT_OUT:
            begin
                op         = lfr_pkg::OP_EMIT_FIT;
                state_next = S_IDLE;
            end
            S_FIT_DG:
            begin
                op         = lfr_pkg::OP_EMIT_DEGEN;
                state_next = S_IDLE;
            end
            S_RES1:
            begin
                op         = lfr_pkg::OP_RES1;
                state_next = S_RES2;
            end
            S_RES2:
            begin
                op         = lfr_pkg::OP_RES2;
                state_next = S_RES3;
            end
            S_RES3:
            begin
                op         = lfr_pkg::OP_RES3;
                state_next = S_RES_SQW;
            end
            S_RES_SQW:
            begin
                if (stat.sqrt_done)
                    state_next = S_RES4;
            end
            S_RES4:
            begin
                op         = lfr_pkg::OP_DIV_RES;
                state_next = S_RES_DW;
            end
            S_RES_DW:
            begin
                if (stat.div_done)
                    state_next = S_RES_OUT;
            end
            S_RES_OUT:
            begin
                op         = lfr_pkg::OP_EMIT_RES;
                state_next = S_IDLE;
            end
            S_RES_NL:
            begin
                op         = lfr_pkg::OP_EMIT_NOLINE;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

    a_busy_match: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (state_reg != S_IDLE))
        else $error("busy does not follow controller state");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> busy_reg)
        else $error("not busy after accepting an item");

endmodule

/* design/line_fit_with_residuals.sv */
// Top level of the least-squares line fit with perpendicular residuals.
// Add point: item accepted, then busy through decode and the two accumulate steps.
// Finish fit: two divisions in series, slope then intercept; a degenerate set skips both.
// Residual: a square root then a division in series; with no kept line, the no-fit result skips both.
// The divider and root unit are shared; one item is in work at a time.
// Asynchronous reset clears sums, kept line and controller; results cannot be stalled.
module line_fit_with_residuals (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  lfr_pkg::in_item_t   in_item,
    output lfr_pkg::out_item_t  result,
    output logic                result_strobe
);

    lfr_pkg::op_t   op;
    lfr_pkg::stat_t stat;

    lfr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .op    (op),
        .busy  (busy)
    );

    lfr_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .in_item       (in_item),
        .stat          (stat),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule

/* tb/lfr_checker.sv */
// Checker for the line fit block: predicts results from accepted items and compares.
`timescale 1ns / 1ps
module lfr_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  lfr_pkg::in_item_t   in_item,
    input  lfr_pkg::out_item_t  result,
    input  logic                result_strobe,
    output int                  fail_count,
    output int                  pending,
    output int                  fit_count,
    output int                  resid_count,
    output int                  degen_count,
    output int                  drop_count
);

    lfr_pkg::out_item_t expected_q[$];

    int      pts;
    longint  sx, sy, sxx, sxy;
    bit      dropped;
    longint  kept_slope, kept_offset;
    bit      kept_valid;

    function automatic longint round_sat(logic signed [127:0] num,
                                         logic signed [127:0] den, int bits);
        logic [127:0] mag;
        logic [127:0] q;
        logic [127:0] lim;
        mag = num[127] ? -num : num;
        q   = ((mag << 1) + den) / (den << 1);
        lim = 128'd1 << (bits - 1);
        if (num[127])
            return (q >= lim) ? -longint'(lim) : -longint'(q);
        return (q >= lim) ? longint'(lim - 1) : longint'(q);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    task automatic predict_fit(input lfr_pkg::in_item_t it);
        longint              x, y;
        logic signed [127:0] n128, sx128, sy128, sxx128, sxy128, den, num;
        logic [63:0]         m, s;
        longint              slope, offset, resid;
        lfr_pkg::out_item_t  r;
        x = it.x_coord;
        y = it.y_coord;
        if (it.kind == lfr_pkg::KIND_ADD)
        begin
            if (pts < lfr_pkg::MAX_POINTS)
            begin
                pts++;
                sx  += x;
                sy  += y;
                sxx += x * x;
                sxy += x * y;
            end
            else
                dropped = 1;
            return;
        end
        if (it.kind != lfr_pkg::KIND_FIT && it.kind != lfr_pkg::KIND_RES)
            return;
        slope  = 0;
        offset = 0;
        resid  = 0;
        r      = '0;
        if (it.kind == lfr_pkg::KIND_FIT)
        begin
            n128 = pts; sx128 = sx; sy128 = sy; sxx128 = sxx; sxy128 = sxy;
            den  = n128 * sxx128 - sx128 * sx128;
            r.result_kind = lfr_pkg::RKIND_FIT;
            r.points_used = 9'(pts);
            if (pts < 2 || den <= 0)
            begin
                r.status   = lfr_pkg::ST_DEGEN;
                kept_valid = 0;
                degen_count++;
            end
            else
            begin
                num    = n128 * sxy128 - sx128 * sy128;
                slope  = round_sat(num <<< 16, den, 32);
                num    = sy128 * 65536 - 128'(slope) * sx128;
                offset = round_sat(num, n128 * 65536, 24);
                kept_slope  = slope;
                kept_offset = offset;
                kept_valid  = 1;
                r.status    = dropped ? lfr_pkg::ST_DROP : lfr_pkg::ST_OK;
                if (dropped)
                    drop_count++;
            end
            pts = 0; sx = 0; sy = 0; sxx = 0; sxy = 0; dropped = 0;
            fit_count++;
        end
        else
        begin
            r.result_kind = lfr_pkg::RKIND_RES;
            if (!kept_valid)
                r.status = lfr_pkg::ST_NOFIT;
            else
            begin
                m = kept_slope < 0 ? 64'(-kept_slope) : 64'(kept_slope);
                s = int_sqrt((64'd1 << 32) + m * m);
                num = 128'(y) * 65536 - 128'(kept_slope) * 128'(x)
                      - 128'(kept_offset) * 65536;
                resid  = round_sat(num, 128'(s), 24);
                slope  = kept_slope;
                offset = kept_offset;
                r.status = lfr_pkg::ST_OK;
            end
            resid_count++;
        end
        r.slope     = slope[31:0];
        r.intercept = offset[23:0];
        r.residual  = resid[23:0];
        expected_q = {expected_q, r};
    endtask

    task automatic report(input string what, input longint exp_v, input longint got_v);
        if (fail_count < 10)
            $display("%0t mismatch %s: expected %0d got %0d", $time, what, exp_v, got_v);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_q.delete();
            pts = 0; sx = 0; sy = 0; sxx = 0; sxy = 0; dropped = 0;
            kept_slope = 0; kept_offset = 0; kept_valid = 0;
            fail_count = 0; fit_count = 0; resid_count = 0;
            degen_count = 0; drop_count = 0;
        end
        else
        begin
            if (result_strobe)
            begin
                if (expected_q.size() == 0)
                    report("unexpected result, status", -1, result.status);
                else
                begin
                    lfr_pkg::out_item_t e;
                    e = expected_q.pop_front();
                    if (e.result_kind !== result.result_kind)
                        report("result_kind", e.result_kind, result.result_kind);
                    if (e.slope !== result.slope)
                        report("slope", e.slope, result.slope);
                    if (e.intercept !== result.intercept)
                        report("intercept", e.intercept, result.intercept);
                    if (e.residual !== result.residual)
                        report("residual", e.residual, result.residual);
                    if (e.points_used !== result.points_used)
                        report("points_used", e.points_used, result.points_used);
                    if (e.status !== result.status)
                        report("status", e.status, result.status);
                end
            end
            if (start && !busy)
                predict_fit(in_item);
        end
        pending = expected_q.size();
    end
endmodule

/* tb/tb_line_fit_with_residuals.sv */
// Testbench top for the line fit block: stimulus, checker hookup and verdict.
`timescale 1ns / 1ps
module tb_line_fit_with_residuals;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    lfr_pkg::in_item_t   in_item;
    lfr_pkg::out_item_t  result;
    logic                result_strobe;
    int         fail_count, pending, fit_count, resid_count, degen_count, drop_count;
    int         sent;
    int         burst_left;

    line_fit_with_residuals u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .in_item       (in_item),
        .result        (result),
        .result_strobe (result_strobe)
    );

    lfr_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .in_item       (in_item),
        .result        (result),
        .result_strobe (result_strobe),
        .fail_count    (fail_count),
        .pending       (pending),
        .fit_count     (fit_count),
        .resid_count   (resid_count),
        .degen_count   (degen_count),
        .drop_count    (drop_count)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // one item; gaps may come between bursts
    task automatic send(input logic [1:0] k, input logic [23:0] x, input logic [23:0] y);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0)
            begin
                start <= 0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
        end
        burst_left--;
        start   <= 1;
        in_item <= '{kind: k, x_coord: x, y_coord: y};
        do @(posedge clk); while (busy);
        sent++;
    endtask

    task automatic drain();
        start <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [23:0] rnd24();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 40) - 20);
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic line_set(input int npts);
        int     m, b, x, noise, span;
        longint y;
        m    = $urandom_range(0, 2047) - 1024;
        b    = $urandom_range(0, 65535) - 32768;
        span = ($urandom_range(0, 3) == 0) ? 8388607 : $urandom_range(100, 200000);
        for (int i = 0; i < npts; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send(lfr_pkg::KIND_ADD, rnd24(), rnd24());
            else
            begin
                x     = $urandom_range(0, 2 * span) - span;
                noise = $urandom_range(0, 512) - 256;
                y     = ((longint'(x) * m) >>> 8) + b + noise;
                send(lfr_pkg::KIND_ADD, x[23:0], y[23:0]);
            end
        end
        send(lfr_pkg::KIND_FIT, rnd24(), rnd24());
        repeat ($urandom_range(0, 4))
            send(lfr_pkg::KIND_RES, rnd24(), rnd24());
    endtask

    initial
    begin
        rst_n      = 0;
        start      = 0;
        in_item    = '0;
        sent       = 0;
        burst_left = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed corners
        send(lfr_pkg::KIND_RES, 24'h7FFFFF, 24'h800000);
        send(lfr_pkg::KIND_FIT, 24'd0, 24'd0);
        send(lfr_pkg::KIND_ADD, 24'h001000, 24'h002000);
        send(lfr_pkg::KIND_FIT, 24'd0, 24'd0);
        send(lfr_pkg::KIND_ADD, 24'h001000, 24'h002000);
        send(lfr_pkg::KIND_ADD, 24'h001000, 24'h7FFFFF);
        send(lfr_pkg::KIND_FIT, 24'd0, 24'd0);
        send(lfr_pkg::KIND_ADD, 24'h800000, 24'h800000);
        send(lfr_pkg::KIND_ADD, 24'h7FFFFF, 24'h7FFFFF);
        send(lfr_pkg::KIND_ADD, 24'h000000, 24'h000000);
        send(2'd3, 24'hFFFFFF, 24'hFFFFFF);
        send(lfr_pkg::KIND_FIT, 24'd0, 24'd0);
        send(lfr_pkg::KIND_RES, 24'h7FFFFF, 24'h800000);
        send(lfr_pkg::KIND_RES, 24'h800000, 24'h7FFFFF);
        send(lfr_pkg::KIND_ADD, 24'h000000, 24'h800000);
        send(lfr_pkg::KIND_ADD, 24'h000001, 24'h7FFFFF);
        send(lfr_pkg::KIND_FIT, 24'd0, 24'd0);
        send(lfr_pkg::KIND_RES, 24'h000000, 24'h000000);
        send(lfr_pkg::KIND_RES, 24'h800000, 24'h800000);
        drain();

        while (sent < 1550)
        begin
            case ($urandom_range(0, 19))
                0: line_set($urandom_range(257, 265));
                1: send(2'd3, rnd24(), rnd24());
                2: send(lfr_pkg::KIND_RES, rnd24(), rnd24());
                3: send(lfr_pkg::KIND_FIT, rnd24(), rnd24());
                4: drain();
                default: line_set($urandom_range(0, 10));
            endcase
        end
        drain();
        repeat (300) @(posedge clk);

        $display("Sent %0d items: %0d fits (%0d degenerate, %0d with dropped points),",
                 sent, fit_count, degen_count, drop_count);
        $display("%0d residual queries, %0d mismatches.", resid_count, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
